// ===== rtl/udpck_pkg.sv =====
`timescale 1ns / 1ps
// udpck_pkg: transaction types, status and mode codes, and ones' complement helpers
// shared by every module of the udp checksum engine; depends on nothing

package udpck_pkg;

  typedef struct packed {
    logic        kind;
    logic        first_word;
    logic        last_word;
    logic [1:0]  last_bytes;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] segment_length;
    logic [15:0] data_word;
  } udp_in_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [1:0]  status;
  } udp_out_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_BAD  = 2'd1,
    ST_MISMATCH = 2'd2
  } udpck_status_t;

  typedef enum logic {
    MODE_GEN    = 1'b0,
    MODE_VERIFY = 1'b1
  } udpck_mode_t;

  // one classified word, handed from the front end to the back end
  typedef struct packed {
    logic        first;
    logic        last;
    udpck_mode_t mode;
    logic        len_bad;
    logic        chk_zero;
    logic [15:0] value;
  } udpck_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } udpck_qstat_t;

  localparam logic [15:0] UDP_PROTO       = 16'd17;
  localparam logic [15:0] MIN_UDP_LEN     = 16'd8;
  localparam logic [15:0] PAD_MASK        = 16'hFF00;
  localparam logic [15:0] ALL_ONES        = 16'hFFFF;
  localparam logic [1:0]  ONE_BYTE        = 2'd1;
  localparam logic [2:0]  CHECK_WORD_POS  = 3'd3;
  localparam logic [2:0]  POS_SAT         = 3'd4;
  localparam int          QUEUE_DEPTH_DEF = 4;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold a sum of up to eight 16-bit words back into 16 bits
  function automatic logic [15:0] fold19(input logic [18:0] t);
    logic [16:0] s1;
    s1 = {1'b0, t[15:0]} + {14'd0, t[18:16]};
    return s1[15:0] + {15'd0, s1[16]};
  endfunction

endpackage

// ===== rtl/udpck_front.sv =====
`timescale 1ns / 1ps
// udpck_front: accepts input words, folds the pseudo header on the first word,
// applies padding and checksum word handling; uses udpck_pkg

module udpck_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  udpck_pkg::udp_in_t      in_data,
  output udpck_pkg::udpck_entry_t entry
);
  import udpck_pkg::*;

  logic [2:0]  pos;
  logic [2:0]  pos_next;
  udpck_mode_t mode;
  udpck_mode_t mode_next;
  logic        len_bad;
  logic        len_bad_next;
  logic        chk_zero;
  logic        chk_zero_next;

  logic [2:0]  pos_eff;
  logic [15:0] word_pad;
  logic [15:0] word_use;
  logic        at_check;
  logic [18:0] ph_total;

  always_comb begin
    pos_eff      = in_data.first_word ? 3'd0 : pos;
    mode_next    = in_data.first_word ? udpck_mode_t'(in_data.kind) : mode;
    len_bad_next = in_data.first_word ? (in_data.segment_length < MIN_UDP_LEN) : len_bad;

    word_pad = (in_data.last_word && in_data.last_bytes == ONE_BYTE) ?
               (in_data.data_word & PAD_MASK) : in_data.data_word;
    at_check = (pos_eff == CHECK_WORD_POS);

    chk_zero_next = in_data.first_word ? 1'b0 : chk_zero;
    word_use      = word_pad;
    if (at_check) begin
      if (mode_next == MODE_GEN) begin
        word_use = '0;
      end else if (word_pad == '0) begin
        chk_zero_next = 1'b1;
      end
    end

    pos_next = (pos_eff == POS_SAT) ? POS_SAT : pos_eff + 3'd1;

    // pseudo header plus the first word, added at once and folded
    ph_total = {3'd0, in_data.source_address[31:16]} + {3'd0, in_data.source_address[15:0]}
             + {3'd0, in_data.dest_address[31:16]} + {3'd0, in_data.dest_address[15:0]}
             + {3'd0, UDP_PROTO} + {3'd0, in_data.segment_length} + {3'd0, word_use};

    entry.first    = in_data.first_word;
    entry.last     = in_data.last_word;
    entry.mode     = mode_next;
    entry.len_bad  = len_bad_next;
    entry.chk_zero = chk_zero_next;
    entry.value    = in_data.first_word ? fold19(ph_total) : word_use;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      mode     <= MODE_GEN;
      len_bad  <= 1'b0;
      chk_zero <= 1'b0;
    end else if (accept) begin
      pos      <= pos_next;
      mode     <= mode_next;
      len_bad  <= len_bad_next;
      chk_zero <= chk_zero_next;
    end
  end

endmodule

// ===== rtl/udpck_queue.sv =====
`timescale 1ns / 1ps
// udpck_queue: small register fifo of classified words between front and back end
// uses udpck_pkg

module udpck_queue #(
  parameter int DEPTH = udpck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  udpck_pkg::udpck_entry_t push_entry,
  input  logic                    pop,
  output udpck_pkg::udpck_entry_t head,
  output udpck_pkg::udpck_qstat_t stat
);
  import udpck_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  udpck_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == CW'(DEPTH));

endmodule

// ===== rtl/udpck_back.sv =====
`timescale 1ns / 1ps
// udpck_back: accumulates classified words and builds the result transaction
// in an output register; uses udpck_pkg

module udpck_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  udpck_pkg::udpck_entry_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output udpck_pkg::udp_out_t     out_data
);
  import udpck_pkg::*;

  logic [15:0] sum;
  logic [15:0] sum_next;
  logic [15:0] comp;
  logic        can_load;
  udp_out_t    res_next;

  always_comb begin
    can_load = !out_valid || !out_stall;
    pop      = head_valid && (!head.last || can_load);
    sum_next = head.first ? head.value : oc_add(sum, head.value);
    comp     = ~sum_next;

    if (head.len_bad) begin
      res_next.checksum_value = '0;
      res_next.status         = ST_LEN_BAD;
    end else if (head.mode == MODE_GEN) begin
      res_next.checksum_value = (comp == '0) ? ALL_ONES : comp;
      res_next.status         = ST_OK;
    end else begin
      res_next.checksum_value = comp;
      res_next.status         = (head.chk_zero || comp == '0) ? ST_OK : ST_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        sum <= sum_next;
      end
      if (pop && head.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_data <= res_next;
    end
  end

endmodule

// ===== rtl/udp_checksum_engine.sv =====
`timescale 1ns / 1ps
// udp_checksum_engine: top level, front end, word queue and back end
// depends on udpck_pkg, udpck_front, udpck_queue, udpck_back

// usage
//   input channel: one 16-bit segment word per transaction (in_valid, in_stall,
//   in_data). the first word also carries source and destination address and
//   udp length; kind on the first word picks generate or verify.
//   output channel: one transaction per segment, on its last word (out_valid,
//   out_stall, out_data) with checksum_value and status.
//   throughput: one word per cycle sustained while in_stall is low; the limit
//   is the single 16-bit end-around-carry add in the back end accumulator.
//   path: an accepted last word is written into the queue, popped from its
//   head into the output register, and from there shows on out_valid.
//   stall: the output register holds while out_stall is high; words keep
//   flowing into the queue (QUEUE_DEPTH entries) until it fills, then
//   in_stall rises. in_stall depends only on queue occupancy.
//   reset: synchronous; clears the queue, the accumulator, the latched mode,
//   length flag and word position; no result is pending afterwards.

module udp_checksum_engine #(
  parameter int QUEUE_DEPTH = udpck_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  udpck_pkg::udp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output udpck_pkg::udp_out_t out_data
);
  import udpck_pkg::*;

  udpck_entry_t front_entry;
  udpck_entry_t head;
  udpck_qstat_t q_stat;
  logic         push;
  logic         pop;

  // input transaction accepted whenever the queue has room
  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  // front end: pseudo header fold, padding, checksum word handling
  udpck_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (push),
    .in_data (in_data),
    .entry   (front_entry)
  );

  // decouples the word stream from output back pressure
  udpck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // back end: running sum and result register
  udpck_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_stat.valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // no result is pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a new result only ever comes from a last word leaving the queue
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head.last))
    else $error("result without a last word");

  // the back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

endmodule
